// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl of the sensor reader
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SWSR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("swsr assertion failed");

// checked at every edge, reset included
`define SWSR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("swsr assertion failed");

`endif

// ----- hw/rtl/swsr_pkg.sv -----
// types, codes and constants of the single wire sensor reader
// no dependencies
`default_nettype none

package swsr_pkg;

  localparam int MaxBits = 40;
  localparam int WordW   = 40;
  localparam int CntW    = 6;
  localparam int TickW   = 16;
  localparam int WidthW  = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // sequencer phases
  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhStartLow  = 3'd1;
  localparam logic [2:0] PhStartHigh = 3'd2;
  localparam logic [2:0] PhResponse  = 3'd3;
  localparam logic [2:0] PhBits      = 3'd4;
  localparam logic [2:0] PhDone      = 3'd5;
  localparam logic [2:0] PhNoResp    = 3'd6;

  // status codes
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StBusy   = 2'd1;
  localparam logic [1:0] StDone   = 2'd2;
  localparam logic [1:0] StNoResp = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgStartLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRespTo    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOneMin    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOneMax    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgZeroMin   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgZeroMax   = 3'd6;

  localparam logic [TickW-1:0]  RstStartLow  = 16'd25000;
  localparam logic [WidthW-1:0] RstStartHigh = 8'd30;
  localparam logic [TickW-1:0]  RstRespTo    = 16'd32000;
  localparam logic [WidthW-1:0] RstOneMin    = 8'd55;
  localparam logic [WidthW-1:0] RstOneMax    = 8'd75;
  localparam logic [WidthW-1:0] RstZeroMin   = 8'd10;
  localparam logic [WidthW-1:0] RstZeroMax   = 8'd30;

  typedef struct packed {
    logic [TickW-1:0]  start_low_ticks;
    logic [WidthW-1:0] start_high_ticks;
    logic [TickW-1:0]  response_timeout;
    logic [WidthW-1:0] one_min_width;
    logic [WidthW-1:0] one_max_width;
    logic [WidthW-1:0] zero_min_width;
    logic [WidthW-1:0] zero_max_width;
  } swsr_cfg_t;

  typedef struct packed {
    logic            req_type;
    logic            line_level;
    logic [CntW-1:0] bits_wanted;
  } swsr_item_t;

  typedef struct packed {
    logic             drive_enable;
    logic             drive_value;
    logic             bit_valid;
    logic             bit_value;
    logic [CntW-1:0]  bit_index;
    logic             last_bit;
    logic [1:0]       status;
    logic [WordW-1:0] data_word;
  } swsr_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swsr_ifs.sv -----
// valid/ready channel interfaces of the sensor reader: input, result, register write
// depends on swsr_pkg
`default_nettype none

interface swsr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic                       line_level;
  logic [swsr_pkg::CntW-1:0]  bits_wanted;
  modport source (output valid, req_type, line_level, bits_wanted, input ready);
  modport sink   (input valid, req_type, line_level, bits_wanted, output ready);
endinterface

interface swsr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       drive_enable;
  logic                       drive_value;
  logic                       bit_valid;
  logic                       bit_value;
  logic [swsr_pkg::CntW-1:0]  bit_index;
  logic                       last_bit;
  logic [1:0]                 status;
  logic [swsr_pkg::WordW-1:0] data_word;
  modport source (output valid, drive_enable, drive_value, bit_valid, bit_value,
                  bit_index, last_bit, status, data_word, input ready);
  modport sink   (input valid, drive_enable, drive_value, bit_valid, bit_value,
                  bit_index, last_bit, status, data_word, output ready);
endinterface

interface swsr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swsr_pkg::CfgIdxW-1:0] index;
  logic [swsr_pkg::CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swsr_cfg_regs.sv -----
// configuration register file of the sensor reader
// depends on swsr_pkg and swsr_cfg_if
`default_nettype none

module swsr_cfg_regs (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  swsr_cfg_if.sink            cfg_i,
  output swsr_pkg::swsr_cfg_t cfg_o
);
  import swsr_pkg::*;

  swsr_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgStartLow:  cfg_d.start_low_ticks  = cfg_i.data;
        CfgStartHigh: cfg_d.start_high_ticks = cfg_i.data[WidthW-1:0];
        CfgRespTo:    cfg_d.response_timeout = cfg_i.data;
        CfgOneMin:    cfg_d.one_min_width    = cfg_i.data[WidthW-1:0];
        CfgOneMax:    cfg_d.one_max_width    = cfg_i.data[WidthW-1:0];
        CfgZeroMin:   cfg_d.zero_min_width   = cfg_i.data[WidthW-1:0];
        CfgZeroMax:   cfg_d.zero_max_width   = cfg_i.data[WidthW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks  <= RstStartLow;
      cfg_q.start_high_ticks <= RstStartHigh;
      cfg_q.response_timeout <= RstRespTo;
      cfg_q.one_min_width    <= RstOneMin;
      cfg_q.one_max_width    <= RstOneMax;
      cfg_q.zero_min_width   <= RstZeroMin;
      cfg_q.zero_max_width   <= RstZeroMax;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swsr_engine.sv -----
// bus sequencer state and one-word step logic of the sensor reader
// depends on swsr_pkg
`default_nettype none

module swsr_engine (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  swsr_pkg::swsr_item_t item_i,
  input  swsr_pkg::swsr_cfg_t  cfg_i,
  output swsr_pkg::swsr_res_t  res_o
);
  import swsr_pkg::*;

  logic [2:0]       phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [CntW-1:0]  rcvd_q, rcvd_d;
  logic [CntW-1:0]  target_q, target_d;
  logic [WordW-1:0] word_q, word_d;
  logic             prev_q, prev_d;

  logic [TickW-1:0] tick_inc;
  logic [TickW-1:0] low_lim, high_lim, to_lim;
  logic [CntW-1:0]  wanted;
  logic [CntW-1:0]  rcvd_inc;
  logic             one_hit, zero_hit, expect_lvl;

  assign tick_inc = tick_q + 16'd1;
  assign rcvd_inc = rcvd_q + 6'd1;
  // zero limits behave as one tick
  assign low_lim  = (cfg_i.start_low_ticks == '0) ? 16'd1 : cfg_i.start_low_ticks;
  assign high_lim = (cfg_i.start_high_ticks == '0) ? 16'd1
                                                   : {8'd0, cfg_i.start_high_ticks};
  assign to_lim   = (cfg_i.response_timeout == '0) ? 16'd1 : cfg_i.response_timeout;

  always_comb begin
    if (item_i.bits_wanted == '0) begin
      wanted = 6'd1;
    end else if (item_i.bits_wanted > CntW'(MaxBits)) begin
      wanted = CntW'(MaxBits);
    end else begin
      wanted = item_i.bits_wanted;
    end
  end

  assign one_hit  = (tick_q >= {8'd0, cfg_i.one_min_width}) &&
                    (tick_q <= {8'd0, cfg_i.one_max_width});
  assign zero_hit = (tick_q >= {8'd0, cfg_i.zero_min_width}) &&
                    (tick_q <= {8'd0, cfg_i.zero_max_width});
  // the middle response wait looks for high
  assign expect_lvl = (rcvd_q == 6'd1);

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    rcvd_d   = rcvd_q;
    target_d = target_q;
    word_d   = word_q;
    prev_d   = prev_q;
    res_o    = '0;

    if (item_i.req_type) begin
      target_d = wanted;
      rcvd_d   = '0;
      word_d   = '0;
      tick_d   = '0;
      prev_d   = 1'b1;
      phase_d  = PhStartLow;
    end else begin
      prev_d = item_i.line_level;
      unique case (phase_q)
        PhStartLow: begin
          tick_d = tick_inc;
          if (tick_inc >= low_lim) begin
            tick_d  = '0;
            phase_d = PhStartHigh;
          end
        end
        PhStartHigh: begin
          tick_d = tick_inc;
          if (tick_inc >= high_lim) begin
            tick_d  = '0;
            rcvd_d  = '0;
            phase_d = PhResponse;
          end
        end
        PhResponse: begin
          if (item_i.line_level == expect_lvl) begin
            tick_d = '0;
            if (rcvd_q >= 6'd2) begin
              rcvd_d  = '0;
              phase_d = PhBits;
            end else begin
              rcvd_d = rcvd_inc;
            end
          end else begin
            tick_d = tick_inc;
            if (tick_inc >= to_lim) begin
              tick_d  = '0;
              rcvd_d  = '0;
              phase_d = PhNoResp;
            end
          end
        end
        PhBits: begin
          if (item_i.line_level) begin
            if (!prev_q) begin
              tick_d = 16'd1;
            end else if (tick_q != '1) begin
              tick_d = tick_inc;
            end
          end else if (prev_q) begin
            tick_d = '0;
            if (one_hit || zero_hit) begin
              res_o.bit_valid = 1'b1;
              res_o.bit_value = one_hit;
              res_o.bit_index = rcvd_q;
              word_d = {word_q[WordW-2:0], one_hit};
              rcvd_d = rcvd_inc;
              if (rcvd_inc >= target_q) begin
                res_o.last_bit = 1'b1;
                phase_d        = PhDone;
              end
            end
          end
        end
        default: ;
      endcase
    end

    res_o.drive_enable = (phase_d == PhStartLow) || (phase_d == PhStartHigh);
    res_o.drive_value  = (phase_d == PhStartHigh);
    res_o.data_word    = word_d;
    priority if (phase_d == PhDone) begin
      res_o.status = StDone;
    end else if (phase_d == PhNoResp) begin
      res_o.status = StNoResp;
    end else if (phase_d == PhIdle) begin
      res_o.status = StIdle;
    end else begin
      res_o.status = StBusy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      tick_q   <= '0;
      rcvd_q   <= '0;
      target_q <= '0;
      word_q   <= '0;
      prev_q   <= 1'b1;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      rcvd_q   <= rcvd_d;
      target_q <= target_d;
      word_q   <= word_d;
      prev_q   <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/single_wire_sensor_reader_core.sv -----
// Single wire temperature/humidity sensor bus master.
// Channels: in_i carries one word per microsecond: a tick with the sampled line
// level, or a start request with the bit count. out_o returns exactly one word
// per input word: line drive enable/value, a decoded bit with its index and
// last flag, the read status and the gathered data word. cfg_i writes the
// seven timing registers by index; it is always ready and must be used only
// while no word is in flight.
// Path: an input word lands in the input register at acceptance and its result
// is registered in the output register when the word advances.
// Throughput: one word per cycle while out_o.ready is high; the sequencer state
// and counter update in a single step between the two registers.
// Reset: both registers empty, sequencer idle, registers at their defaults.
// Stall: while out_o.ready is low the result waits in the output register and
// one more input word is taken into the input register, then in_i.ready drops.
// depends on swsr_pkg, swsr_ifs, swsr_cfg_regs, swsr_engine, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module single_wire_sensor_reader_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  swsr_in_if.sink    in_i,
  swsr_out_if.source out_o,
  swsr_cfg_if.sink   cfg_i
);
  import swsr_pkg::*;

  swsr_cfg_t  cfg;
  swsr_item_t in_q;
  logic       in_valid_q, in_valid_d;
  swsr_res_t  res, out_q;
  logic       out_valid_q, out_valid_d;
  logic       advance, in_take;

  swsr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  swsr_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // the held word moves on when the output register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type    <= in_i.req_type;
      in_q.line_level  <= in_i.line_level;
      in_q.bits_wanted <= in_i.bits_wanted;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_enable = out_q.drive_enable;
  assign out_o.drive_value  = out_q.drive_value;
  assign out_o.bit_valid    = out_q.bit_valid;
  assign out_o.bit_value    = out_q.bit_value;
  assign out_o.bit_index    = out_q.bit_index;
  assign out_o.last_bit     = out_q.last_bit;
  assign out_o.status       = out_q.status;
  assign out_o.data_word    = out_q.data_word;

  `SWSR_ASSERT(a_drive_only_busy, out_valid_q && out_q.drive_enable |-> out_q.status == StBusy)
  `SWSR_ASSERT(a_last_means_done, out_valid_q && out_q.last_bit |-> out_q.bit_valid && out_q.status == StDone)
  `SWSR_ASSERT(a_no_bit_no_fields, out_valid_q && !out_q.bit_valid |-> !out_q.bit_value && !out_q.last_bit && out_q.bit_index == '0)
  `SWSR_ASSERT(a_held_word_kept, in_valid_q && !advance |=> in_valid_q && $stable(in_q))
  `SWSR_ASSERT_ALWAYS(a_ready_when_empty, !in_valid_q |-> in_i.ready)

endmodule

`default_nettype wire
